// ===== rtl/core/lsh_pkg.sv =====
// Shared widths, constants and types for the latency statistics histogram.
// No dependencies; imported by lsh_serial_div, latency_stats_histogram_top and the testbench.
`default_nettype none

package lsh_pkg;

   localparam int SAMPLE_W = 40;   // latency sample, min, max, average
   localparam int WIDTH_W  = 32;   // bucket width register
   localparam int COUNT_W  = 24;   // sample count and bucket counters
   localparam int SUM_W    = 64;   // running sum, never wraps
   localparam int INDEX_W  = 8;    // bucket index as seen on the result port

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET = WIDTH_W'(1000000);
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = '1;

   // status of one serial divider as seen by its controller
   typedef struct packed {
      logic busy;   // shifting quotient bits
      logic done;   // one-cycle pulse after the last quotient bit
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/lsh_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on lsh_pkg (div_status_type).
`default_nettype none

module lsh_serial_div
   import lsh_pkg::*;
#(
   parameter int NUM_W = 64,
   parameter int DEN_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [NUM_W-1:0] quot,
   output div_status_type   status
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic [NUM_W-1:0] q_ff, q_in;      // dividend bits out at the top, quotient in below
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             borrow;

   assign trial  = {rem_ff, q_ff[NUM_W-1]};
   assign diff   = {1'b0, trial} - {2'b00, den_ff};
   assign borrow = diff[DEN_W+1];

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ~borrow};
         rem_in = borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot        = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/latency_stats_histogram_top.sv =====
// Latency statistics: running min/max/count/average and a bucket histogram.
// Depends on lsh_pkg and lsh_serial_div.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+-----------------------------------
//   req_      | in        | req_valid/req_ready  | sample_value (40)
//   rsp_      | out       | rsp_valid/rsp_ready  | min, max, count, average, bucket
//   csr_      | in        | csr_valid/csr_ready  | bucket_width (32), always ready
//
// Each item steps through accept, divider start, the serial average division
// (sum / count, 64 bits), the divider's done, histogram read, write and result
// load; the next sample is taken only after the result load. The index division
// (sample / bucket_width, 40 bits) runs alongside and ends first. After reset a
// clearing pass zeroes every histogram bucket with req_ready low; csr writes are
// taken throughout. A full result register stalls the load and so the sample input.
`default_nettype none

module latency_stats_histogram_top
   import lsh_pkg::*;
#(
   parameter int NUM_BUCKETS = 256
) (
   input  logic                clock,
   input  logic                reset,
   // sample input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample_value,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_min_value,
   output logic [SAMPLE_W-1:0] rsp_max_value,
   output logic [COUNT_W-1:0]  rsp_sample_count,
   output logic [SAMPLE_W-1:0] rsp_average_value,
   output logic [INDEX_W-1:0]  rsp_bucket_index,
   output logic [COUNT_W-1:0]  rsp_bucket_count,
   output logic                rsp_count_saturated,
   // bucket width register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WIDTH_W-1:0]  csr_bucket_width
);

   localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam logic [IDX_W-1:0]    LAST_BUCKET     = IDX_W'(NUM_BUCKETS - 1);
   localparam logic [SAMPLE_W-1:0] LAST_BUCKET_WIDE = SAMPLE_W'(NUM_BUCKETS - 1);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR = 3'd0;   // histogram clearing pass
   localparam logic [2:0] ST_IDLE  = 3'd1;   // waiting for a sample
   localparam logic [2:0] ST_START = 3'd2;   // kick both dividers
   localparam logic [2:0] ST_DIV   = 3'd3;   // serial divisions running
   localparam logic [2:0] ST_READ  = 3'd4;   // bucket counter read
   localparam logic [2:0] ST_WRITE = 3'd5;   // bucket counter update
   localparam logic [2:0] ST_OUT   = 3'd6;   // load result register

   logic [2:0] state_ff, state_in;

   // configuration
   logic [WIDTH_W-1:0] width_ff;

   // running statistics
   logic [SAMPLE_W-1:0] min_ff, max_ff, sample_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [COUNT_W-1:0]  count_ff;

   // histogram
   logic [COUNT_W-1:0] bucket_mem [NUM_BUCKETS];
   logic [COUNT_W-1:0] rd_ff;
   logic [IDX_W-1:0]   clear_addr_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [COUNT_W-1:0] bucket_new;
   logic [COUNT_W-1:0] bucket_new_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [COUNT_W-1:0] mem_wdata;

   // dividers
   logic                div_start;
   logic [SAMPLE_W-1:0] idx_quot;
   logic [SUM_W-1:0]    avg_quot;
   div_status_type      idx_stat, avg_stat;
   logic [IDX_W-1:0]    idx_clamped;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, out_load;

   logic accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign div_start = (state_ff == ST_START);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == ST_OUT) && out_free;

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == LAST_BUCKET) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_START;
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            // average division is the longer one; index is already captured
            if (avg_stat.done && !idx_stat.busy) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // bucket width register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_bucket_width;
      end
   end

   // ------------------------------------------------------------------
   // min / max / sum / count, updated on accept
   // sum and count freeze once the count saturates; min and max do not
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= SAMPLE_MAX;
         max_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         if (req_sample_value < min_ff) min_ff <= req_sample_value;
         if (req_sample_value > max_ff) max_ff <= req_sample_value;
         if (count_ff != COUNT_MAX) begin
            sum_ff   <= sum_ff + SUM_W'(req_sample_value);
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) sample_ff <= req_sample_value;
   end

   // ------------------------------------------------------------------
   // serial dividers: bucket index and average
   // a zero bucket width yields an all-ones quotient, so it clamps to the
   // last bucket; count is never zero once a sample is in
   // ------------------------------------------------------------------
   lsh_serial_div #(
      .NUM_W (SAMPLE_W),
      .DEN_W (WIDTH_W)
   ) u_idx_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (sample_ff),
      .denom  (width_ff),
      .quot   (idx_quot),
      .status (idx_stat)
   );

   lsh_serial_div #(
      .NUM_W (SUM_W),
      .DEN_W (COUNT_W)
   ) u_avg_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (sum_ff),
      .denom  (count_ff),
      .quot   (avg_quot),
      .status (avg_stat)
   );

   assign idx_clamped = (idx_quot > LAST_BUCKET_WIDE) ? LAST_BUCKET : idx_quot[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (idx_stat.done) idx_ff <= idx_clamped;
   end

   // ------------------------------------------------------------------
   // histogram memory: one write port, one registered read port
   // ------------------------------------------------------------------
   assign bucket_new = (rd_ff == COUNT_MAX) ? rd_ff : rd_ff + 1'b1;
   assign mem_we     = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign mem_waddr  = (state_ff == ST_CLEAR) ? clear_addr_ff : idx_ff;
   assign mem_wdata  = (state_ff == ST_CLEAR) ? '0 : bucket_new;

   always_ff @(posedge clock) begin
      if (mem_we) bucket_mem[mem_waddr] <= mem_wdata;
      rd_ff <= bucket_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) bucket_new_ff <= bucket_new;
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_min_value       <= min_ff;
         rsp_max_value       <= max_ff;
         rsp_sample_count    <= count_ff;
         rsp_average_value   <= avg_quot[SAMPLE_W-1:0];
         rsp_bucket_index    <= INDEX_W'(idx_ff);
         rsp_bucket_count    <= bucket_new_ff;
         rsp_count_saturated <= (count_ff == COUNT_MAX);
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // a delivered bucket count has just been incremented, so it is never zero
   a_bucket_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bucket_count != '0))
      else $error("bucket count zero in result");

   // the average of the samples lies between the extremes seen so far
   a_avg_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_min_value <= rsp_average_value) &&
                     (rsp_average_value <= rsp_max_value)))
      else $error("average outside min/max");

   // saturation flag tracks the delivered count
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_saturated == (rsp_sample_count == COUNT_MAX)))
      else $error("saturation flag inconsistent with count");

   // no item is taken while the dividers are still shifting
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (idx_stat.busy || avg_stat.busy) |-> !req_ready)
      else $error("ready raised during division");

   // the histogram write of an item is followed by the result load stage
   a_write_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (state_ff == ST_OUT))
      else $error("bucket write not followed by result load");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for latency_stats_histogram_top: a directed table, then random
// samples under several widths, each result checked against a local predictor or table.
// Depends on lsh_pkg and the RTL of latency_stats_histogram_top.

module testbench
   import lsh_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH    = 256;  // NUM_BUCKETS of the instance
   localparam int HIST_IDX_W    = $clog2(HIST_DEPTH);
   localparam int ITEM_CYCLES   = 70;   // cycles of one item in the block
   localparam int HOLD_CYCLES   = 600;  // long receiver hold-off, several items' worth
   localparam int PHASE_ITEMS   = 250;
   localparam int NUM_PHASES    = 7;
   localparam int NUM_ROWS      = 20;

   // one result item as seen on the rsp_ port
   typedef struct packed {
      logic [SAMPLE_W-1:0] min_value;
      logic [SAMPLE_W-1:0] max_value;
      logic [COUNT_W-1:0]  sample_count;
      logic [SAMPLE_W-1:0] average_value;
      logic [INDEX_W-1:0]  bucket_index;
      logic [COUNT_W-1:0]  bucket_count;
      logic                count_saturated;
   } stats_type;

   // one row of the directed table; want is only used where known is set
   typedef struct {
      bit                  wr;
      logic [WIDTH_W-1:0]  width;
      logic [SAMPLE_W-1:0] sample;
      bit                  known;
      stats_type           want;
   } vector_type;

   localparam stats_type NONE = '0;

   // ---------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [SAMPLE_W-1:0] req_sample_value = '0;
   logic                rsp_ready = 1'b0;
   logic                csr_valid = 1'b0;
   logic [WIDTH_W-1:0]  csr_bucket_width = WIDTH_RESET;

   logic                req_ready;
   logic                rsp_valid;
   logic [SAMPLE_W-1:0] rsp_min_value;
   logic [SAMPLE_W-1:0] rsp_max_value;
   logic [COUNT_W-1:0]  rsp_sample_count;
   logic [SAMPLE_W-1:0] rsp_average_value;
   logic [INDEX_W-1:0]  rsp_bucket_index;
   logic [COUNT_W-1:0]  rsp_bucket_count;
   logic                rsp_count_saturated;
   logic                csr_ready;

   always #5 clock = ~clock;

   latency_stats_histogram_top #(
      .NUM_BUCKETS (HIST_DEPTH)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_value    (req_sample_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_min_value       (rsp_min_value),
      .rsp_max_value       (rsp_max_value),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_average_value   (rsp_average_value),
      .rsp_bucket_index    (rsp_bucket_index),
      .rsp_bucket_count    (rsp_bucket_count),
      .rsp_count_saturated (rsp_count_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_bucket_width    (csr_bucket_width)
   );

   // ---------------------------------------------------------------------
   // Predictor state: mirrors the block from reset onwards
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] seen_min      = SAMPLE_MAX;
   logic [SAMPLE_W-1:0] seen_max      = '0;
   logic [SUM_W-1:0]    seen_sum      = '0;
   logic [COUNT_W-1:0]  seen_count    = '0;
   logic [COUNT_W-1:0]  hist_count [HIST_DEPTH];
   logic [WIDTH_W-1:0]  width_setting = WIDTH_RESET;

   stats_type pending_stats [$];   // results still owed by the block, oldest first
   int        error_count = 0;

   // idling controls shared between the sender (main process) and the receiver
   int     sender_idle_pct   = 0;
   int     receiver_idle_pct = 0;
   bit     hold_request      = 1'b0;

   initial begin
      foreach (hist_count[i]) hist_count[i] = '0;
   end

   // Directed table. Only the first two rows after reset have their result typed
   // in; the rest go through the predictor. Rows with wr set change the bucket
   // width once the block has gone idle.
   vector_type directed_rows [NUM_ROWS] = '{
      // zero sample straight after reset: everything lands in bucket 0
      '{1'b0, '0, 40'h0, 1'b1,
        '{40'h0, 40'h0, 24'd1, 40'h0, 8'd0, 24'd1, 1'b0}},
      // largest sample: well past the last bucket, so clamped to 255
      '{1'b0, '0, 40'hFF_FFFF_FFFF, 1'b1,
        '{40'h0, 40'hFF_FFFF_FFFF, 24'd2, 40'h7F_FFFF_FFFF, 8'd255, 24'd1, 1'b0}},
      // bucket edges at the reset width
      '{1'b0, '0, 40'd999999,    1'b0, NONE},
      '{1'b0, '0, 40'd1000000,   1'b0, NONE},
      '{1'b0, '0, 40'd255000000, 1'b0, NONE},
      '{1'b0, '0, 40'd255999999, 1'b0, NONE},
      '{1'b0, '0, 40'd256000000, 1'b0, NONE},
      // narrowest width: index equals the sample until it clamps
      '{1'b1, 32'd1, 40'd0,   1'b0, NONE},
      '{1'b0, '0,    40'd255, 1'b0, NONE},
      '{1'b0, '0,    40'd256, 1'b0, NONE},
      '{1'b0, '0,    40'hAA_AAAA_AAAA, 1'b0, NONE},
      // zero width: divider gives all ones, so always the last bucket
      '{1'b1, 32'd0, 40'd5, 1'b0, NONE},
      '{1'b0, '0,    40'd0, 1'b0, NONE},
      // widest width
      '{1'b1, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0, NONE},
      '{1'b0, '0,            40'hFF_FFFF_FFFE, 1'b0, NONE},
      '{1'b0, '0,            40'h00_FFFF_FFFF, 1'b0, NONE},
      '{1'b0, '0,            40'h55_5555_5555, 1'b0, NONE},
      // back to the reset width
      '{1'b1, WIDTH_RESET, 40'd1,            1'b0, NONE},
      '{1'b0, '0,          40'h80_0000_0000, 1'b0, NONE},
      '{1'b0, '0,          40'd127999999,    1'b0, NONE}
   };

   // Advance the predictor by one accepted sample and return the result it owes.
   function automatic stats_type stats_after_sample(logic [SAMPLE_W-1:0] s);
      stats_type              r;
      logic [SUM_W-1:0]       quot;
      logic [HIST_IDX_W-1:0]  bkt;
      if (s < seen_min) seen_min = s;
      if (s > seen_max) seen_max = s;
      // sum and count freeze once the count has saturated
      if (seen_count != COUNT_MAX) begin
         seen_sum   = seen_sum + SUM_W'(s);
         seen_count = seen_count + 1'b1;
      end
      if (width_setting == '0) begin
         quot = SUM_W'(HIST_DEPTH - 1);
      end else begin
         quot = SUM_W'(s) / SUM_W'(width_setting);
         if (quot > SUM_W'(HIST_DEPTH - 1)) quot = SUM_W'(HIST_DEPTH - 1);
      end
      bkt = quot[HIST_IDX_W-1:0];
      if (hist_count[bkt] != COUNT_MAX) hist_count[bkt] = hist_count[bkt] + 1'b1;
      r.min_value       = seen_min;
      r.max_value       = seen_max;
      r.sample_count    = seen_count;
      r.average_value   = (seen_count == '0) ? '0 : SAMPLE_W'(seen_sum / SUM_W'(seen_count));
      r.bucket_index    = quot[INDEX_W-1:0];
      r.bucket_count    = hist_count[bkt];
      r.count_saturated = (seen_count == COUNT_MAX);
      return r;
   endfunction

   // Random sample shaped around the current width: bucket edges, the histogram
   // span, tiny values and the full 40-bit range.
   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SUM_W-1:0] full;
      logic [SUM_W-1:0] span;
      full = {$urandom, $urandom};
      span = SUM_W'(width_setting) * SUM_W'(HIST_DEPTH);
      case ($urandom_range(9))
         0: return full[SAMPLE_W-1:0];
         1: return $urandom_range(1) ? SAMPLE_MAX : '0;
         2: return SAMPLE_W'(SUM_W'($urandom_range(HIST_DEPTH + 1)) * SUM_W'(width_setting)
                   + SUM_W'($urandom_range(2)) - SUM_W'(1));
         3, 4, 5, 6: begin
            if (width_setting == '0) return full[SAMPLE_W-1:0];
            return SAMPLE_W'(full % (span + 1));
         end
         7: return SAMPLE_W'($urandom_range(1000));
         default: return full[SAMPLE_W-1:0] >> $urandom_range(SAMPLE_W - 1);
      endcase
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Offer one sample, hold it until taken, then queue what it should produce
   // and idle for a while as the current setting says.
   task automatic offer_sample(logic [SAMPLE_W-1:0] s, bit known, stats_type want);
      stats_type predicted;
      int        gap;
      req_valid        <= 1'b1;
      req_sample_value <= s;
      do @(posedge clock); while (!req_ready);
      predicted = stats_after_sample(s);
      pending_stats.push_back(known ? want : predicted);
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      // now and then a long gap so that it falls on every part of the item's work
      if (sender_idle_pct > 0 && $urandom_range(15) == 0) gap += $urandom_range(1, 90);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every owed result has arrived.
   task automatic finish_outstanding();
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   task automatic write_width(logic [WIDTH_W-1:0] w);
      csr_valid        <= 1'b1;
      csr_bucket_width <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      width_setting  = w;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin sender_idle_pct = 28; receiver_idle_pct = 52; end
         1: begin sender_idle_pct = 52; receiver_idle_pct = 28; end
         default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Receiver: checks each accepted result, then picks the next rsp_ready.
   // A hold-off request keeps rsp_ready low so the output register fills and
   // the block has to stall its input.
   // ---------------------------------------------------------------------
   initial begin
      int        hold_left;
      stats_type got;
      stats_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_min_value, rsp_max_value, rsp_sample_count, rsp_average_value,
                    rsp_bucket_index, rsp_bucket_count, rsp_count_saturated};
            if (pending_stats.size() == 0) begin
               $error("result item arrived with no sample outstanding");
               error_count++;
            end else begin
               want = pending_stats.pop_front();
               compare_field("min_value",       64'(want.min_value),       64'(got.min_value));
               compare_field("max_value",       64'(want.max_value),       64'(got.max_value));
               compare_field("sample_count",    64'(want.sample_count),    64'(got.sample_count));
               compare_field("average_value",   64'(want.average_value),   64'(got.average_value));
               compare_field("bucket_index",    64'(want.bucket_index),    64'(got.bucket_index));
               compare_field("bucket_count",    64'(want.bucket_count),    64'(got.bucket_count));
               compare_field("count_saturated", 64'(want.count_saturated),
                             64'(got.count_saturated));
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence: reset, directed table, random phases, wind-down.
   // Widths only change once the block has gone idle.
   // ---------------------------------------------------------------------
   initial begin
      logic [WIDTH_W-1:0] phase_width;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part; the block's clearing pass holds req_ready low at first
      set_idling(0);
      foreach (directed_rows[r]) begin
         if (directed_rows[r].wr) begin
            finish_outstanding();
            write_width(directed_rows[r].width);
         end
         offer_sample(directed_rows[r].sample, directed_rows[r].known, directed_rows[r].want);
      end

      // random part: receiver-heavy idling, then sender-heavy, then none
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: phase_width = WIDTH_RESET;
            1: phase_width = WIDTH_W'($urandom_range(1, 4000));
            2: phase_width = $urandom;
            3: phase_width = '1;
            4: phase_width = WIDTH_W'(1);
            5: phase_width = '0;
            default: phase_width = WIDTH_W'($urandom_range(1000, 100000));
         endcase
         finish_outstanding();
         write_width(phase_width);
         set_idling(phase < 2 ? 0 : (phase < 4 ? 1 : 2));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver stall while the sender keeps offering
            if ((phase == 1 || phase == 5) && i == 10) hold_request = 1'b1;
            offer_sample(random_sample(), 1'b0, NONE);
         end
      end

      // drain, then give any stray result time to show up
      finish_outstanding();
      repeat (2 * ITEM_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_stats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #25_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
